FILE: sv/tbmfm_pkg.sv
// Shared types, constants and the MFM cell encoding function for the track
// byte to MFM cell unit. No dependencies.
package tbmfm_pkg;

  localparam logic [7:0]  SyncC2Byte  = 8'hC2;
  localparam logic [7:0]  SyncA1Byte  = 8'hA1;
  localparam logic [15:0] SyncC2Word  = 16'h5224;
  localparam logic [15:0] SyncA1Word  = 16'h4489;
  localparam logic [7:0]  HeaderMark  = 8'hFE;
  localparam logic [7:0]  DataMark    = 8'hFB;
  localparam logic [10:0] BaseSector  = 11'd128;
  localparam logic [10:0] HeaderCopy  = 11'd6;
  localparam logic [10:0] DataExtra   = 11'd2;
  localparam logic [10:0] SizeByteAt  = 11'd3;
  localparam int unsigned QueueDepthDefault = 4;

  // What follows the flushed held bytes of one job
  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_DATA,
    TAIL_SYNC
  } tbmfm_tail_e;

  // One job: flush_cnt words of hbyte, then the tail
  typedef struct packed {
    logic [1:0]  flush_cnt;
    logic [7:0]  hbyte;
    tbmfm_tail_e tail;
    logic [7:0]  tbyte;
    logic        eot;
  } tbmfm_job_t;

  // Clock cell is 1 only when the previous cell and the data bit are both 0
  function automatic logic [15:0] mfm_encode(input logic [7:0] b, input logic prev);
    logic [15:0] w;
    logic        p;
    w = '0;
    p = prev;
    for (int k = 7; k >= 0; k--) begin
      w[2*k+1] = ~p & ~b[k];
      w[2*k]   = b[k];
      p        = b[k];
    end
    return w;
  endfunction

endpackage

FILE: sv/tbmfm_front.sv
// Front end: accepts track bytes, tracks sync runs, address marks and field
// copies, and turns each byte into at most one job. Depends on tbmfm_pkg.
module tbmfm_front import tbmfm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  input  logic       track_end_i,
  output logic       push_o,
  output tbmfm_job_t job_o
);

  logic [7:0]  held_q, held_d;
  logic [1:0]  hcnt_q, hcnt_d;
  logic        mark_q, mark_d;
  logic [10:0] copy_q, copy_d;
  logic [1:0]  size_q, size_d;
  logic        in_hdr_q, in_hdr_d;

  logic        handled;
  logic [2:0]  cnt_next;
  tbmfm_job_t  job;
  logic [1:0]  words;

  always_comb begin
    held_d   = held_q;
    hcnt_d   = hcnt_q;
    mark_d   = mark_q;
    copy_d   = copy_q;
    size_d   = size_q;
    in_hdr_d = in_hdr_q;
    handled  = 1'b0;
    cnt_next = {1'b0, hcnt_q} + 3'd1;
    job.flush_cnt = 2'd0;
    job.hbyte     = held_q;
    job.tail      = TAIL_NONE;
    job.tbyte     = data_byte_i;
    job.eot       = track_end_i;

    if (copy_q != '0) begin
      if (in_hdr_q && copy_q == SizeByteAt) begin
        size_d = data_byte_i[1:0];
      end
      job.tail = TAIL_DATA;
      copy_d   = copy_q - 11'd1;
      if (copy_d == '0) begin
        in_hdr_d = 1'b0;
      end
    end else begin
      if (mark_q) begin
        mark_d = 1'b0;
        if (data_byte_i == HeaderMark) begin
          in_hdr_d = 1'b1;
          copy_d   = HeaderCopy;
          job.tail = TAIL_DATA;
          handled  = 1'b1;
        end else if (data_byte_i == DataMark) begin
          in_hdr_d = 1'b0;
          copy_d   = (BaseSector << size_q) + DataExtra;
          job.tail = TAIL_DATA;
          handled  = 1'b1;
        end
      end
      if (!handled) begin
        if (hcnt_q != '0 && data_byte_i == held_q) begin
          if (cnt_next == 3'd3) begin
            job.tail = TAIL_SYNC;
            hcnt_d   = 2'd0;
            if (data_byte_i == SyncA1Byte) begin
              mark_d = 1'b1;
            end
          end else begin
            hcnt_d = cnt_next[1:0];
          end
        end else begin
          // Broken run: flush old candidates, then hold or encode this byte
          job.flush_cnt = hcnt_q;
          if (data_byte_i == SyncC2Byte || data_byte_i == SyncA1Byte) begin
            held_d = data_byte_i;
            hcnt_d = 2'd1;
          end else begin
            job.tail = TAIL_DATA;
            hcnt_d   = 2'd0;
          end
        end
      end
    end

    // Track end: flush whatever is still held after this byte
    if (track_end_i && job.tail == TAIL_NONE) begin
      if (job.flush_cnt == 2'd0) begin
        job.flush_cnt = hcnt_d;
        job.hbyte     = held_d;
      end else begin
        job.tail = TAIL_DATA;
      end
    end
  end

  always_comb begin
    unique case (job.tail)
      TAIL_DATA: words = job.flush_cnt + 2'd1;
      TAIL_SYNC: words = 2'd3;
      default:   words = job.flush_cnt;
    endcase
  end

  assign push_o = accept_i && (words != 2'd0);
  assign job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q   <= '0;
      hcnt_q   <= '0;
      mark_q   <= 1'b0;
      copy_q   <= '0;
      size_q   <= '0;
      in_hdr_q <= 1'b0;
    end else if (accept_i) begin
      if (track_end_i) begin
        held_q   <= '0;
        hcnt_q   <= '0;
        mark_q   <= 1'b0;
        copy_q   <= '0;
        size_q   <= '0;
        in_hdr_q <= 1'b0;
      end else begin
        held_q   <= held_d;
        hcnt_q   <= hcnt_d;
        mark_q   <= mark_d;
        copy_q   <= copy_d;
        size_q   <= size_d;
        in_hdr_q <= in_hdr_d;
      end
    end
  end

  // A track end always produces at least one word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && track_end_i) |-> push_o)
    else $error("track end produced no job");

  // Track state is cleared after a track end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && track_end_i) |=> (hcnt_q == '0 && copy_q == '0 && !mark_q))
    else $error("track state not cleared after track end");

endmodule

FILE: sv/tbmfm_queue.sv
// Small job queue between the front end and the cell back end.
// Depends on tbmfm_pkg for the job type.
module tbmfm_queue import tbmfm_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  tbmfm_job_t job_i,
  input  logic       pop_i,
  output logic       full_o,
  output logic       empty_o,
  output tbmfm_job_t head_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(Depth);

  tbmfm_job_t       mem_q [Depth];
  logic [AddrW-1:0] wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == LastAddr) ? '0 : wr_q + AddrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == LastAddr) ? '0 : rd_q + AddrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i |-> !full_o) and (pop_i |-> !empty_o))
    else $error("queue overflow or underflow");

endmodule

FILE: sv/tbmfm_back.sv
// Back end: expands queued jobs into MFM cell words, one per cycle while the output
// is not stalled, with the cell chain carried across words. Depends on tbmfm_pkg.
module tbmfm_back import tbmfm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  tbmfm_job_t  head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] cell_word_o,
  output logic        last_of_run_o,
  output logic        end_of_track_o
);

  logic [1:0]  idx_q;
  logic        prev_q;
  logic        vld_q;
  logic [15:0] word_q;
  logic        last_q, eot_q;

  logic        load, emit, is_last;
  logic [1:0]  words;
  logic [15:0] word;

  always_comb begin
    unique case (head_i.tail)
      TAIL_DATA: words = head_i.flush_cnt + 2'd1;
      TAIL_SYNC: words = 2'd3;
      default:   words = head_i.flush_cnt;
    endcase
  end

  always_comb begin
    if (idx_q < head_i.flush_cnt) begin
      word = mfm_encode(head_i.hbyte, prev_q);
    end else if (head_i.tail == TAIL_SYNC) begin
      word = (head_i.tbyte == SyncA1Byte) ? SyncA1Word : SyncC2Word;
    end else begin
      word = mfm_encode(head_i.tbyte, prev_q);
    end
  end

  assign load    = !vld_q || out_ready_i;
  assign emit    = load && !empty_i;
  assign is_last = (idx_q == words - 2'd1);
  assign pop_o   = emit && is_last;

  always_ff @(posedge clk_i) begin
    if (emit) begin
      word_q <= word;
      last_q <= is_last;
      eot_q  <= is_last && head_i.eot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      idx_q  <= '0;
      prev_q <= 1'b0;
    end else begin
      if (load) begin
        vld_q <= !empty_i;
      end
      if (emit) begin
        idx_q  <= is_last ? 2'd0 : idx_q + 2'd1;
        prev_q <= (is_last && head_i.eot) ? 1'b0 : word[0];
      end
    end
  end

  assign out_valid_o    = vld_q;
  assign cell_word_o    = word_q;
  assign last_of_run_o  = last_q;
  assign end_of_track_o = eot_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> (!eot_q || last_q))
    else $error("end of track flagged on a word that is not last of run");

endmodule

FILE: sv/track_byte_to_mfm_cells_unit.sv
// Track byte to MFM cell unit: jobs pass the job queue and an output register;
// one byte per cycle is taken while the job queue has room. Output runs at one
// word per cycle while the sink is ready; sync bursts and flushes give up to
// three words per byte, which the job queue absorbs before the input stalls.
// Reset (async, active low) clears run, mark, copy, size and cell state.
module track_byte_to_mfm_cells_unit import tbmfm_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // track_end
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [15:0] cell_word
  output logic        m_axis_tlast_o,   // last_of_run
  output logic        m_axis_tuser_o    // [0] end_of_track
);

  logic       accept;
  logic       push, pop, full, empty;
  tbmfm_job_t job, head;

  // Take a transfer whenever the queue can hold the job it may create
  assign s_axis_tready_o = !full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // Front end: classify the byte and build its job
  tbmfm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (s_axis_tdata_i),
    .track_end_i (s_axis_tlast_i),
    .push_o      (push),
    .job_o       (job)
  );

  // Decouple the byte side from the word side
  tbmfm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  // Back end: expand jobs into cell words behind an output register
  tbmfm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .cell_word_o    (m_axis_tdata_o),
    .last_of_run_o  (m_axis_tlast_o),
    .end_of_track_o (m_axis_tuser_o)
  );

endmodule

FILE: tb/mfm_cell_checker.sv
// Cell word checker for the track byte to MFM cell unit: follows both stream
// channels, predicts the cell words of every byte transfer and compares them.
// Depends on tbmfm_pkg for the sync and mark constants.
module mfm_cell_checker import tbmfm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        byte_valid_i,
  input  logic        byte_ready_i,
  input  logic [7:0]  byte_data_i,
  input  logic        byte_last_i,
  input  logic        cell_valid_i,
  input  logic        cell_ready_i,
  input  logic [15:0] cell_data_i,
  input  logic        cell_last_i,
  input  logic        cell_eot_i,
  output int unsigned mismatch_count_o,
  output int unsigned words_due_o
);

  typedef struct packed {
    logic [15:0] cells;
    logic        run_end;
    logic        track_end;
  } cell_word_t;

  cell_word_t  words_due[$];
  int unsigned mismatch_cnt;

  // Shadow of the encoder's track state
  logic [7:0]  held_byte;
  logic [1:0]  held_count;
  logic        mark_seen;
  logic [10:0] copy_left;
  logic [1:0]  size_code;
  logic        last_cell;
  logic        in_header;

  // Words produced by the byte under prediction
  logic [15:0] step_words[3];
  int unsigned step_count;

  function automatic logic [15:0] cells_of(input logic [7:0] data, input logic prev_cell);
    logic [15:0] w;
    logic        p;
    w = '0;
    p = prev_cell;
    for (int k = 7; k >= 0; k--) begin
      w = {w[13:0], ~p & ~data[k], data[k]};
      p = data[k];
    end
    return w;
  endfunction

  task automatic clear_track();
    held_byte  = '0;
    held_count = '0;
    mark_seen  = 1'b0;
    copy_left  = '0;
    size_code  = '0;
    last_cell  = 1'b0;
    in_header  = 1'b0;
  endtask

  task automatic emit(input logic [15:0] w);
    if (step_count < 3) step_words[step_count] = w;
    step_count++;
    last_cell = w[0];
  endtask

  task automatic flush_held();
    for (int k = 0; k < held_count; k++) emit(cells_of(held_byte, last_cell));
    held_count = '0;
  endtask

  task automatic encode_track_byte(input logic [7:0] data, input logic track_done);
    logic        taken;
    logic [15:0] sync_word;
    int unsigned n;
    step_count = 0;
    taken      = 1'b0;
    if (copy_left != '0) begin
      // Inside a header or data field: copy without sync detection
      if (in_header && copy_left == SizeByteAt) size_code = data[1:0];
      emit(cells_of(data, last_cell));
      copy_left--;
      if (copy_left == '0) in_header = 1'b0;
    end else begin
      if (mark_seen) begin
        mark_seen = 1'b0;
        if (data == HeaderMark) begin
          in_header = 1'b1;
          copy_left = HeaderCopy;
          emit(cells_of(data, last_cell));
          taken = 1'b1;
        end else if (data == DataMark) begin
          in_header = 1'b0;
          copy_left = (BaseSector << size_code) + DataExtra;
          emit(cells_of(data, last_cell));
          taken = 1'b1;
        end
      end
      if (!taken) begin
        if (held_count != '0 && data == held_byte) begin
          held_count++;
          if (held_count == 2'd3) begin
            sync_word = (data == SyncA1Byte) ? SyncA1Word : SyncC2Word;
            repeat (3) emit(sync_word);
            held_count = '0;
            if (data == SyncA1Byte) mark_seen = 1'b1;
          end
        end else begin
          flush_held();
          if (data == SyncC2Byte || data == SyncA1Byte) begin
            held_byte  = data;
            held_count = 2'd1;
          end else begin
            emit(cells_of(data, last_cell));
          end
        end
      end
    end
    if (track_done) begin
      flush_held();
      clear_track();
    end
    n = (step_count > 3) ? 3 : step_count;
    for (int k = 0; k < n; k++)
      words_due.push_back('{step_words[k], k == n - 1, track_done && k == n - 1});
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cell_word_t seen, want;
    if (!rst_ni) begin
      clear_track();
      words_due.delete();
      mismatch_cnt     = 0;
      mismatch_count_o <= 0;
      words_due_o      <= 0;
    end else begin
      // Compare first: no word can leave in the cycle its byte arrives
      if (cell_valid_i && cell_ready_i) begin
        seen = '{cell_data_i, cell_last_i, cell_eot_i};
        if (words_due.size() == 0) begin
          $display("%0t: unexpected cell word, expected none, got %h last %b eot %b",
                   $realtime, seen.cells, seen.run_end, seen.track_end);
          mismatch_cnt++;
        end else begin
          want = words_due.pop_front();
          if (seen !== want) begin
            $display("%0t: cell word mismatch, expected %h last %b eot %b, got %h last %b eot %b",
                     $realtime, want.cells, want.run_end, want.track_end,
                     seen.cells, seen.run_end, seen.track_end);
            mismatch_cnt++;
          end
        end
      end
      if (byte_valid_i && byte_ready_i) encode_track_byte(byte_data_i, byte_last_i);
      mismatch_count_o <= mismatch_cnt;
      words_due_o      <= words_due.size();
    end
  end

endmodule

FILE: tb/track_byte_to_mfm_cells_unit_test.sv
// Testbench top for the track byte to MFM cell unit: drives track bytes,
// paces the cell word sink and gives the verdict.
// Depends on tbmfm_pkg, track_byte_to_mfm_cells_unit and mfm_cell_checker.
module track_byte_to_mfm_cells_unit_test;
  import tbmfm_pkg::*;

  localparam int unsigned OpeningCount = 26;
  localparam int unsigned RandomBytes  = 384;
  localparam int unsigned TailCycles   = 16;
  // Worst case is far below this: every byte's words behind the longest sink stall
  localparam int unsigned CycleLimit   = 400000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        byte_valid = 1'b0;
  logic        byte_ready;
  logic [7:0]  byte_data  = '0;
  logic        byte_last  = 1'b0;
  logic        cell_valid;
  logic        cell_ready = 1'b0;
  logic [15:0] cell_data;
  logic        cell_last;
  logic        cell_eot;

  int unsigned mismatches;
  int unsigned words_due;
  int unsigned cycles = 0;

  // Stimulus bookkeeping
  int unsigned sent        = 0;
  logic        steady_send = 1'b0;
  logic [1:0]  stim_size   = '0;

  // Directed opening: {track_end, data_byte}
  logic [8:0] opening[OpeningCount] = '{
    9'h0FF,                                       // all ones
    9'h0C2, 9'h0C2, 9'h041,                       // broken C2 run
    9'h0A1, 9'h0A1, 9'h0A1, 9'h0FE,               // header mark
    9'h001, 9'h002, 9'h003, 9'h000, 9'h005, 9'h006, // header, size byte at fourth
    9'h0A1, 9'h0A1, 9'h0A1, 9'h0FB, 9'h13C,       // data field cut by track end
    9'h0A1, 9'h0A1, 9'h1C2,                       // held run flushed at track end
    9'h0A1, 9'h0A1, 9'h0A1, 9'h07F                // mark with no field behind it
  };

  track_byte_to_mfm_cells_unit uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (byte_valid),
    .s_axis_tready_o (byte_ready),
    .s_axis_tdata_i  (byte_data),
    .s_axis_tlast_i  (byte_last),
    .m_axis_tvalid_o (cell_valid),
    .m_axis_tready_i (cell_ready),
    .m_axis_tdata_o  (cell_data),
    .m_axis_tlast_o  (cell_last),
    .m_axis_tuser_o  (cell_eot)
  );

  mfm_cell_checker cell_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .byte_valid_i     (byte_valid),
    .byte_ready_i     (byte_ready),
    .byte_data_i      (byte_data),
    .byte_last_i      (byte_last),
    .cell_valid_i     (cell_valid),
    .cell_ready_i     (cell_ready),
    .cell_data_i      (cell_data),
    .cell_last_i      (cell_last),
    .cell_eot_i       (cell_eot),
    .mismatch_count_o (mismatches),
    .words_due_o      (words_due)
  );

  initial begin : clock_gen
    forever #6 clk = ~clk;
  end

  // Bound the run: a hung handshake or lost word ends here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one byte and hold it until the transfer completes
  task automatic send_byte(input logic [7:0] data, input logic track_done);
    int unsigned gap;
    gap = steady_send ? 0 : pick_gap();
    if (gap != 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_data  <= data;
    byte_last  <= track_done;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    sent++;
    if (track_done) stim_size = '0;
  endtask

  // Three equal sync candidates: a full address or index mark
  task automatic send_mark(input logic [7:0] data);
    repeat (3) send_byte(data, 1'b0);
  endtask

  // Sink pacing: stretches of steady ready mixed with random stalls
  initial begin : sink_pacing
    int unsigned gap;
    wait (rst_n);
    @(posedge clk);
    forever begin
      cell_ready <= 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(30, 90)) @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 6)) @(posedge clk);
        gap = pick_gap();
        if (gap != 0) begin
          cell_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned pick;
    int unsigned count;
    int unsigned field_len;
    logic        ends;
    logic        drained;
    logic [7:0]  value;

    drained = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (opening[i]) send_byte(opening[i][7:0], opening[i][8]);

    while (sent < OpeningCount + RandomBytes) begin
      // Switch between paced and back-to-back sending now and then
      if ($urandom_range(0, 39) == 0) steady_send = ~steady_send;

      // Once, halfway through, hold off until every word is out
      if (!drained && sent > (OpeningCount + RandomBytes) / 2) begin
        byte_valid <= 1'b0;
        @(posedge clk);
        while (words_due != 0) @(posedge clk);
        drained = 1'b1;
      end

      pick = $urandom_range(0, 99);
      ends = ($urandom_range(0, 19) == 0);
      if (pick < 22) begin
        // Header: mark, FE, six bytes, size code in the fourth
        send_mark(SyncA1Byte);
        send_byte(HeaderMark, 1'b0);
        for (int i = 0; i < 6; i++) begin
          value = 8'($urandom_range(0, 255));
          if (i == 3) begin
            if ($urandom_range(0, 5) != 0) value[1:0] = 2'b00;
            stim_size = value[1:0];
          end
          send_byte(value, ends && i == 5);
        end
      end else if (pick < 34) begin
        // Data field: copy in full for some small sectors, else cut by track end
        send_mark(SyncA1Byte);
        send_byte(DataMark, 1'b0);
        field_len = (int'(BaseSector) << stim_size) + int'(DataExtra);
        if (stim_size == 2'd0 && $urandom_range(0, 1) == 0) begin
          for (int i = 0; i < field_len; i++)
            send_byte(8'($urandom_range(0, 255)), ends && i == field_len - 1);
        end else begin
          count = $urandom_range(1, 20);
          for (int i = 0; i < count; i++)
            send_byte(8'($urandom_range(0, 255)), i == count - 1);
        end
      end else if (pick < 62) begin
        // Sync candidate run of one to four, maybe broken, maybe at track end
        value = (pick < 50) ? SyncC2Byte : SyncA1Byte;
        count = $urandom_range(1, 4);
        for (int i = 0; i < count; i++)
          send_byte(value, i == count - 1 && $urandom_range(0, 7) == 0);
        if ($urandom_range(0, 1) == 0) send_byte(8'($urandom_range(0, 255)), ends);
      end else begin
        // Plain noise bytes
        count = $urandom_range(1, 6);
        repeat (count) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 24) == 0);
      end
    end

    // Drop valid and let the last words drain
    byte_valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    if (mismatches == 0 && words_due == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
